>>> sv/ccx_pkg.sv
// ccx_pkg: shared types, constants and round functions for the ChaCha20 stream XOR block.
// No dependencies; imported by ccx_ctrl, ccx_dp and chacha20_stream_xor.
package ccx_pkg;

  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = 16;
  localparam int NUM_ROUNDS  = 20;
  localparam int ROUND_CNT_W = $clog2(NUM_ROUNDS);
  localparam int DATA_W      = 8;
  localparam int OFFSET_W    = 38;
  localparam int BLK_W       = 32;
  localparam int POS_W       = OFFSET_W - BLK_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int KEY_REGS    = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_WORDS-1:0] state_t;

  // "expand 32-byte k", word 0 in the low slot
  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0     = 3'd0,
    CFG_KEY1     = 3'd1,
    CFG_KEY2     = 3'd2,
    CFG_KEY3     = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // capture input transfer
    logic load_init;  // load initial state for a new block
    logic round;      // one round of the round unit
    logic diag;       // diagonal round when set, column round otherwise
    logic finalize;   // add initial state, mark cache valid
    logic emit;       // load output register
  } ccx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;        // cached block matches held offset
    logic out_free;   // output register can take a result
  } ccx_status_t;

  function automatic word_t rotl(word_t v, int s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  // four quarter rounds in parallel; sh = 0 column, sh = 1 diagonal
  function automatic state_t qround_set(state_t w_in, int sh);
    state_t w;
    int ia, ib, ic, id;
    w = w_in;
    for (int i = 0; i < 4; i++) begin
      ia = i;
      ib = 4 + ((i + sh) & 3);
      ic = 8 + ((i + 2 * sh) & 3);
      id = 12 + ((i + 3 * sh) & 3);
      w[ia] = w[ia] + w[ib]; w[id] = rotl(w[id] ^ w[ia], 16);
      w[ic] = w[ic] + w[id]; w[ib] = rotl(w[ib] ^ w[ic], 12);
      w[ia] = w[ia] + w[ib]; w[id] = rotl(w[id] ^ w[ia], 8);
      w[ic] = w[ic] + w[id]; w[ib] = rotl(w[ib] ^ w[ic], 7);
    end
    return w;
  endfunction

endpackage

>>> sv/ccx_ctrl.sv
// ccx_ctrl: sequencer for input capture, cache lookup, block rounds and result hand-off.
// Depends on ccx_pkg; drives ccx_dp through ccx_cmd_t, reads ccx_status_t.
module ccx_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ccx_pkg::ccx_status_t status,
  output ccx_pkg::ccx_cmd_t    cmd
);
  import ccx_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_ROUND,
    ST_FINAL
  } state_t;

  state_t                 state_r;
  logic [ROUND_CNT_W-1:0] rcnt_r;

  assign in_tready = (state_r == ST_IDLE);

  // command decode
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.accept = in_tvalid;
      ST_LOOK: begin
        cmd.emit      = status.hit & status.out_free;
        cmd.load_init = ~status.hit;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.diag  = rcnt_r[0];
      end
      ST_FINAL: cmd.finalize = 1'b1;
      default:  cmd = '0;
    endcase
  end

  // state and round counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rcnt_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) state_r <= ST_LOOK;
        end
        ST_LOOK: begin
          if (!status.hit) begin
            state_r <= ST_ROUND;
            rcnt_r  <= '0;
          end else if (status.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        ST_ROUND: begin
          rcnt_r <= rcnt_r + 1'b1;
          if (rcnt_r == ROUND_CNT_W'(NUM_ROUNDS - 1)) state_r <= ST_FINAL;
        end
        ST_FINAL: state_r <= ST_LOOK;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ccx_dp.sv
// ccx_dp: configuration registers, input hold, round unit, cached keystream block and output.
// Depends on ccx_pkg; sequenced by ccx_ctrl.
module ccx_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ccx_pkg::ccx_cmd_t               cmd,
  output ccx_pkg::ccx_status_t            status,
  input  logic [ccx_pkg::DATA_W-1:0]      in_data,
  input  logic [ccx_pkg::OFFSET_W-1:0]    in_offset,
  input  logic                            in_last,
  input  logic                            cfg_valid,
  input  logic [ccx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccx_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ccx_pkg::DATA_W-1:0]      out_data,
  output logic                            out_last
);
  import ccx_pkg::*;

  logic [CFG_DATA_W-1:0] key_r [KEY_REGS];
  logic [CFG_DATA_W-1:0] nonce_lo_r;
  logic [WORD_W-1:0]     nonce_hi_r;
  logic                  cfg_known;

  logic                  cache_valid_r;
  logic [BLK_W-1:0]      cached_idx_r;
  state_t                w_r;
  state_t                init;
  state_t                w_col, w_diag, w_sum;

  logic [DATA_W-1:0]     data_r;
  logic [OFFSET_W-1:0]   off_r;
  logic                  last_r;
  logic [BLK_W-1:0]      blk;
  logic [POS_W-1:0]      pos;
  word_t                 ks_word;
  logic [DATA_W-1:0]     ks_byte;

  logic [DATA_W-1:0]     out_data_r;
  logic                  out_last_r;
  logic                  out_valid_r, out_valid_nxt;

  // configuration writes
  always_comb begin
    case (cfg_idx_t'(cfg_index))
      CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3,
      CFG_NONCE_LO, CFG_NONCE_HI: cfg_known = 1'b1;
      default:                    cfg_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_REGS; i++) key_r[i] <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KEY0:     key_r[0]   <= cfg_data;
        CFG_KEY1:     key_r[1]   <= cfg_data;
        CFG_KEY2:     key_r[2]   <= cfg_data;
        CFG_KEY3:     key_r[3]   <= cfg_data;
        CFG_NONCE_LO: nonce_lo_r <= cfg_data;
        CFG_NONCE_HI: nonce_hi_r <= cfg_data[WORD_W-1:0];
        default:      ;
      endcase
    end
  end

  // initial block state, counter taken from the held offset
  always_comb begin
    for (int i = 0; i < 4; i++) init[i] = SIGMA[i];
    for (int i = 0; i < KEY_REGS; i++) begin
      init[4 + 2 * i] = key_r[i][WORD_W-1:0];
      init[5 + 2 * i] = key_r[i][CFG_DATA_W-1:WORD_W];
    end
    init[12] = blk;
    init[13] = nonce_lo_r[WORD_W-1:0];
    init[14] = nonce_lo_r[CFG_DATA_W-1:WORD_W];
    init[15] = nonce_hi_r;
  end

  // round unit: one column or diagonal round per cycle; w_sum adds the initial state for finalize
  always_comb begin
    w_col  = qround_set(w_r, 0);
    w_diag = qround_set(w_r, 1);
    for (int i = 0; i < NUM_WORDS; i++) w_sum[i] = w_r[i] + init[i];
  end

  assign blk = off_r[OFFSET_W-1:POS_W];
  assign pos = off_r[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_init)     w_r <= init;
    else if (cmd.round)    w_r <= cmd.diag ? w_diag : w_col;
    else if (cmd.finalize) w_r <= w_sum;
  end

  // cache tag: load_init sets index, clears valid; finalize sets valid; cfg writes clear valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_valid_r <= 1'b0;
      cached_idx_r  <= '0;
    end else begin
      if (cfg_valid && cfg_known) cache_valid_r <= 1'b0;
      else if (cmd.load_init)     cache_valid_r <= 1'b0;
      else if (cmd.finalize)      cache_valid_r <= 1'b1;
      if (cmd.load_init) cached_idx_r <= blk;
    end
  end

  // input hold
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      data_r <= in_data;
      off_r  <= in_offset;
      last_r <= in_last;
    end
  end

  // keystream byte select
  assign ks_word = w_r[pos[POS_W-1:2]];
  assign ks_byte = DATA_W'(ks_word >> {pos[1:0], 3'b000});

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit)  out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (cmd.emit) begin
      out_data_r <= data_r ^ ks_byte;
      out_last_r <= last_r;
    end
  end

  assign status.hit      = cache_valid_r && (cached_idx_r == blk);
  assign status.out_free = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

>>> sv/chacha20_stream_xor.sv
// ChaCha20 (RFC 7539) stream XOR: each input transfer carries one byte and its absolute
// stream offset; the result is that byte XOR the keystream byte at that offset. One 64-byte
// keystream block is cached. A byte in the cached block is captured, looked up and loaded
// into the output register. A byte in another block, or the first byte after reset or after
// a key or nonce write, goes through state load, 20 rounds through the single round unit
// (one column or diagonal round per cycle), the final add and the lookup. One byte is in
// work at a time; the output register lets the next byte enter while a result waits.
// Write key and nonce only while the block is idle; cfg_ready is always high.
// Depends on ccx_pkg, ccx_ctrl, ccx_dp.
module chacha20_stream_xor (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [7:0] data_in, [45:8] stream offset, [47:46] zero
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ccx_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,     // end_of_buffer
  // out_tdata: [7:0] data_out
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ccx_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,    // end_of_buffer_out
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ccx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccx_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ccx_pkg::*;

  ccx_cmd_t    cmd;
  ccx_status_t status;

  assign cfg_ready = 1'b1;

  ccx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ccx_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_tdata[DATA_W-1:0]),
    .in_offset (in_tdata[DATA_W+OFFSET_W-1:DATA_W]),
    .in_last   (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
